[rtl/ass_pkg.sv]
// Shared types, constants and the arctangent table of the annulus sector strip generator.
`default_nettype none
package ass_pkg;

   localparam int MAX_SIDES_DEFAULT     = 31;
   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_LEN              = 24;

   // Q4.30 start vector with the CORDIC gain folded in, and the unit clamp
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE   = 34'sd1073741824;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } seq_state_type;

   // per-vertex data that rides along with the CORDIC pipeline
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        rad;
      logic [5:0]         idx;
      logic               last;
   } side_type;

   // one vertex word from the sequencer
   typedef struct packed {
      logic        vld;
      logic [15:0] ang;
      side_type    side;
   } seq_word_type;

   // arctangent of 2^-i in 2^32 units per turn
   function automatic logic signed [31:0] atan_entry(input int i);
      logic signed [31:0] v;
      case (i)
         0:       v = 32'sd536870912;
         1:       v = 32'sd316933406;
         2:       v = 32'sd167458907;
         3:       v = 32'sd85004756;
         4:       v = 32'sd42667331;
         5:       v = 32'sd21354465;
         6:       v = 32'sd10679838;
         7:       v = 32'sd5340245;
         8:       v = 32'sd2670163;
         9:       v = 32'sd1335087;
         10:      v = 32'sd667544;
         11:      v = 32'sd333772;
         12:      v = 32'sd166886;
         13:      v = 32'sd83443;
         14:      v = 32'sd41722;
         15:      v = 32'sd20861;
         16:      v = 32'sd10430;
         17:      v = 32'sd5215;
         18:      v = 32'sd2608;
         19:      v = 32'sd1304;
         20:      v = 32'sd652;
         21:      v = 32'sd326;
         22:      v = 32'sd163;
         23:      v = 32'sd81;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/ass_if.sv]
// Request and response channel interfaces of the annulus sector strip generator.
`default_nettype none
interface ass_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic [30:0]        inner_radius;
   logic [30:0]        outer_radius;
   logic signed [19:0] start_angle;
   logic signed [19:0] end_angle;
   logic [4:0]         side_count;

   modport source (output valid, center_x, center_y, inner_radius, outer_radius,
                   start_angle, end_angle, side_count, input ready);
   modport sink   (input valid, center_x, center_y, inner_radius, outer_radius,
                   start_angle, end_angle, side_count, output ready);
endinterface

interface ass_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vertex_x;
   logic signed [31:0] vertex_y;
   logic [5:0]         vertex_index;
   logic               last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_index, last_vertex,
                   input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_index, last_vertex,
                   output ready);
endinterface
`default_nettype wire

[rtl/ass_seq.sv]
// Request sequencer: angle step division and per-vertex angle and radius generation.
`default_nettype none
module ass_seq #(
   parameter int MAX_SIDES = ass_pkg::MAX_SIDES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   ass_req_if.sink              req_chan,
   input  logic                 take,
   output ass_pkg::seq_word_type word
);
   import ass_pkg::*;

   localparam logic [4:0] MAX_N     = 5'(MAX_SIDES);
   localparam int         DIV_STEPS = 21;

   seq_state_type      state_ff, state_in;
   logic signed [31:0] cx_ff, cy_ff;
   logic [30:0]        rin_ff, rout_ff;
   logic [15:0]        a0_ff, a1_ff;
   logic               neg_ff;
   logic [5:0]         m_ff, last_idx_ff, v_ff;
   logic [20:0]        num_ff;
   logic [6:0]         rem_ff;
   logic [4:0]         cnt_ff;
   logic [15:0]        q_ff;
   logic [5:0]         r_ff;

   logic [4:0]         n_sel;
   logic signed [20:0] delta;
   logic [6:0]         trial;
   logic               bit_q;
   logic [6:0]         r_sum;
   logic               wrap;
   logic [15:0]        step_ang;

   // clamp the side count
   always_comb begin
      if (req_chan.side_count == 5'd0) begin
         n_sel = 5'd1;
      end else if (req_chan.side_count > MAX_N) begin
         n_sel = MAX_N;
      end else begin
         n_sel = req_chan.side_count;
      end
      delta = 21'(req_chan.end_angle) - 21'(req_chan.start_angle);
   end

   // restoring divide step of |delta| by 2(n-1)
   always_comb begin
      trial = {rem_ff[5:0], num_ff[20]};
      bit_q = (trial >= {1'b0, m_ff});
   end

   // step the k*|delta|/m accumulator
   always_comb begin
      r_sum = {1'b0, r_ff} + rem_ff;
      wrap  = (m_ff != 6'd0) && (r_sum >= {1'b0, m_ff});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_chan.valid) state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = ST_EMIT;
         ST_EMIT: if (take && v_ff == last_idx_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture request, divide, then walk the vertices
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cx_ff       <= req_chan.center_x;
            cy_ff       <= req_chan.center_y;
            rin_ff      <= req_chan.inner_radius;
            rout_ff     <= req_chan.outer_radius;
            a0_ff       <= req_chan.start_angle[15:0];
            a1_ff       <= req_chan.end_angle[15:0];
            neg_ff      <= delta[20];
            num_ff      <= delta[20] ? 21'(-delta) : 21'(delta);
            m_ff        <= {n_sel, 1'b0} - 6'd2;
            last_idx_ff <= {n_sel, 1'b0};
            rem_ff      <= 7'd0;
            cnt_ff      <= 5'd0;
            v_ff        <= 6'd0;
            q_ff        <= 16'd0;
            r_ff        <= 6'd0;
         end
         ST_DIV: begin
            rem_ff <= bit_q ? trial - {1'b0, m_ff} : trial;
            num_ff <= {num_ff[19:0], bit_q};
            cnt_ff <= cnt_ff + 5'd1;
         end
         ST_EMIT: begin
            if (take) begin
               v_ff <= v_ff + 6'd1;
               if (v_ff != 6'd0) begin
                  q_ff <= q_ff + num_ff[15:0] + {15'd0, wrap};
                  r_ff <= wrap ? 6'(r_sum - {1'b0, m_ff}) : r_sum[5:0];
               end
            end
         end
         default: ;
      endcase
   end

   assign step_ang = a0_ff + (neg_ff ? 16'(-q_ff) : q_ff);

   // present the current vertex
   always_comb begin
      word.vld       = (state_ff == ST_EMIT);
      word.side.last = (v_ff == last_idx_ff);
      word.ang       = word.side.last ? a1_ff : step_ang;
      word.side.rad  = v_ff[0] ? rin_ff : rout_ff;
      word.side.cx   = cx_ff;
      word.side.cy   = cy_ff;
      word.side.idx  = v_ff;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

[rtl/annulus_sector_strip_generator_core.sv]
// Top level: request sequencer, pipelined CORDIC and coordinate output stages.
// A request of side count n (0 read as 1, above MAX_SIDES clamped) yields 2n+1
// vertices. After acceptance the sequencer runs a bit-serial divide of the
// angle span by 2(n-1), then issues one vertex per cycle, unless the response
// side stalls, into a CORDIC_STAGES+4 deep pipeline. The next request is
// accepted as soon as the last vertex has left the sequencer. A stall on the
// response side freezes the whole pipeline.
`default_nettype none
module annulus_sector_strip_generator_core #(
   parameter int MAX_SIDES     = ass_pkg::MAX_SIDES_DEFAULT,
   parameter int CORDIC_STAGES = ass_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ass_req_if.sink   req_chan,
   ass_rsp_if.source rsp_chan
);
   import ass_pkg::*;

   localparam int N = CORDIC_STAGES;

   seq_word_type       word;
   logic               adv;

   logic               cv_ff   [0:N];
   side_type           cs_ff   [0:N];
   logic [1:0]         cq_ff   [0:N];
   logic signed [33:0] cxr_ff  [0:N];
   logic signed [33:0] cyr_ff  [0:N];
   logic signed [31:0] czr_ff  [0:N];

   logic [15:0]        qsum;
   logic [1:0]         quad;
   logic [15:0]        resid;

   logic               rv_ff, mv_ff, ov_ff;
   side_type           rs_ff, ms_ff;
   logic signed [31:0] cos_ff, sin_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [33:0] xcl, ycl;
   logic signed [31:0] cos_in, sin_in;
   logic signed [63:0] offx, offy;
   logic signed [33:0] sumx, sumy;
   logic signed [31:0] ox_ff, oy_ff;
   logic [5:0]         oidx_ff;
   logic               olast_ff;

   ass_seq #(.MAX_SIDES(MAX_SIDES)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (adv),
      .word     (word)
   );

   // advance everything unless the output word is stalled
   assign adv = !ov_ff || rsp_chan.ready;

   // split the angle into quadrant and residual
   always_comb begin
      qsum  = word.ang + 16'd8192;
      quad  = qsum[15:14];
      resid = word.ang - {quad, 14'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= word.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_ff[0]  <= word.side;
         cq_ff[0]  <= quad;
         cxr_ff[0] <= CORDIC_X0;
         cyr_ff[0] <= 34'sd0;
         czr_ff[0] <= {resid, 16'd0};
      end
   end

   // rotation stages, one micro-rotation each
   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [33:0] xs, ys;
      assign xs = cxr_ff[i] >>> i;
      assign ys = cyr_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cs_ff[i+1] <= cs_ff[i];
            cq_ff[i+1] <= cq_ff[i];
            if (!czr_ff[i][31]) begin
               cxr_ff[i+1] <= cxr_ff[i] - ys;
               cyr_ff[i+1] <= cyr_ff[i] + xs;
               czr_ff[i+1] <= czr_ff[i] - atan_entry(i);
            end else begin
               cxr_ff[i+1] <= cxr_ff[i] + ys;
               cyr_ff[i+1] <= cyr_ff[i] - xs;
               czr_ff[i+1] <= czr_ff[i] + atan_entry(i);
            end
         end
      end
   end

   // clamp to unit and rotate by quadrant
   always_comb begin
      xcl = cxr_ff[N];
      ycl = cyr_ff[N];
      if (xcl > Q30_ONE) xcl = Q30_ONE;
      if (xcl < -Q30_ONE) xcl = -Q30_ONE;
      if (ycl > Q30_ONE) ycl = Q30_ONE;
      if (ycl < -Q30_ONE) ycl = -Q30_ONE;
      case (cq_ff[N])
         2'd0:    begin cos_in = xcl[31:0];        sin_in = ycl[31:0];        end
         2'd1:    begin cos_in = 32'(-ycl);        sin_in = xcl[31:0];        end
         2'd2:    begin cos_in = 32'(-xcl);        sin_in = 32'(-ycl);        end
         default: begin cos_in = ycl[31:0];        sin_in = 32'(-xcl);        end
      endcase
   end

   // round the products and add the centre; the sums saturate in the output stage
   always_comb begin
      offx = (px_ff + 64'sd536870912) >>> 30;
      offy = (py_ff + 64'sd536870912) >>> 30;
      sumx = 34'(ms_ff.cx) + offx[33:0];
      sumy = 34'(ms_ff.cy) + offy[33:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= cv_ff[N];
         mv_ff <= rv_ff;
         ov_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rs_ff    <= cs_ff[N];
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         ms_ff    <= rs_ff;
         px_ff    <= $signed({1'b0, rs_ff.rad}) * cos_ff;
         py_ff    <= $signed({1'b0, rs_ff.rad}) * sin_ff;
         oidx_ff  <= ms_ff.idx;
         olast_ff <= ms_ff.last;
         if (sumx > 34'sd2147483647) begin
            ox_ff <= 32'h7FFF_FFFF;
         end else if (sumx < -34'sd2147483648) begin
            ox_ff <= 32'h8000_0000;
         end else begin
            ox_ff <= sumx[31:0];
         end
         if (sumy > 34'sd2147483647) begin
            oy_ff <= 32'h7FFF_FFFF;
         end else if (sumy < -34'sd2147483648) begin
            oy_ff <= 32'h8000_0000;
         end else begin
            oy_ff <= sumy[31:0];
         end
      end
   end

   assign rsp_chan.valid        = ov_ff;
   assign rsp_chan.vertex_x     = ox_ff;
   assign rsp_chan.vertex_y     = oy_ff;
   assign rsp_chan.vertex_index = oidx_ff;
   assign rsp_chan.last_vertex  = olast_ff;

   // the strip always closes on an even vertex index
   a_last_even: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_vertex |-> !rsp_chan.vertex_index[0])
      else $error("last vertex on odd index");

   // no new request while the sequencer still issues vertices
   a_busy: assert property (@(posedge clock) disable iff (reset)
      word.vld |-> !req_chan.ready)
      else $error("request ready while issuing vertices");

   // a stalled output word does not advance the pipeline
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp_chan.ready |=> $stable(oidx_ff) && ov_ff)
      else $error("output changed under stall");

endmodule
`default_nettype wire
